// ----- sv/scfp_pkg.sv -----
// Package for the serial command frame parser.
// Holds the shared types, command words and byte constants.
// No dependencies.
package scfp_pkg;

  localparam int unsigned DEF_DATA_DEPTH = 24;
  localparam int unsigned MAX_RESULTS    = 32;
  localparam int unsigned KEY_STEPS      = 10;

  localparam logic [31:0] WORD_KEY  = "KEY ";
  localparam logic [31:0] WORD_LCD  = "LCD ";
  localparam logic [31:0] WORD_LCDC = "LCDC";
  localparam logic [31:0] WORD_LED  = "LED ";
  localparam logic [31:0] WORD_LOOP = "LOOP";

  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7f;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_TWO  = 8'h32;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_LCD    = 2'd1;
  localparam logic [1:0] KIND_CURSOR = 2'd2;
  localparam logic [1:0] KIND_LED    = 2'd3;

  typedef enum logic [1:0] {
    PM_IDLE = 2'd0,
    PM_CMD  = 2'd1,
    PM_DATA = 2'd2
  } pmode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY,
    ST_FETCH,
    ST_LCD,
    ST_CURSOR,
    ST_LED,
    ST_LOOP_CMD,
    ST_LOOP_DATA,
    ST_LOOP_PAD
  } seq_e;

  // Byte idx of a four-character word, first character at idx 0.
  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  function automatic logic is_printable(input logic [7:0] v);
    return (v >= PRINT_LO) && (v < PRINT_HI);
  endfunction

endpackage

// ----- sv/scfp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module scfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 25,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/serial_command_frame_parser_core.sv -----
// Serial command frame parser: assembles command frames from serial bytes and
// plays out the replies. Uses scfp_pkg and scfp_ram for the data buffer.
// Flow: a key event enters the key state, a closing zero enters the fetch
//   state, which reads three buffer bytes into the argument registers; each
//   result loads once the output is free, buffer bytes once read data settles.
// Throughput: one result per cycle while the output is taken; a run holds the
//   input off until its last result is registered (up to 32 results).
// Reset: control state and buffer valid bits clear at once; unwritten buffer
//   entries read as zero, so no clearing pass is needed.
module serial_command_frame_parser_core
  import scfp_pkg::*;
#(
  parameter int unsigned DATA_DEPTH = DEF_DATA_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] code_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] value_byte_o,
  output logic [7:0] arg_a_o,
  output logic [7:0] arg_b_o,
  output logic [7:0] arg_c_o,
  output logic       last_o
);

  localparam int unsigned MEM_DEPTH = DATA_DEPTH + 1;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned RCW       = $clog2(MAX_RESULTS);
  localparam logic [AW-1:0]  LAST_IDX  = AW'(DATA_DEPTH);
  localparam logic [AW-1:0]  LOOP_END  = AW'(DATA_DEPTH - 1);
  localparam logic [RCW-1:0] RC_LAST   = RCW'(MAX_RESULTS - 1);
  localparam logic [3:0]     KEY_LAST  = 4'(KEY_STEPS - 1);

  // Parser state
  pmode_e        mode_q, mode_d;
  logic [2:0]    cmd_cnt_q, cmd_cnt_d;
  logic [AW-1:0] data_cnt_q, data_cnt_d;
  logic [7:0]    cmd_q [4];
  logic [7:0]    cmd_d [4];
  logic [7:0]    key_q, key_d;

  // Sequencer state
  seq_e           state_q, state_d;
  logic [3:0]     step_q, step_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [1:0]     fc_q, fc_d;
  logic [RCW-1:0] rc_q, rc_d;
  logic [7:0]     a0_q, a0_d, a1_q, a1_d, a2_q, a2_d;
  logic           rdv_q;

  // Buffer
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata, rdata_m;
  logic [MEM_DEPTH-1:0] vld_q;
  logic              rvld_q;

  // Output register
  logic       out_vld_q;
  logic [1:0] out_kind_q;
  logic [7:0] out_val_q, out_a_q, out_b_q, out_c_q;
  logic       out_last_q;

  logic       acc, start_key, start_frame;
  logic       out_free, ld, nat_last, res_last, mem_adv;
  logic [1:0] o_kind;
  logic [7:0] o_val, o_a, o_b, o_c;
  logic [31:0] cmd_word;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;
  assign cmd_word   = {cmd_q[0], cmd_q[1], cmd_q[2], cmd_q[3]};
  assign rdata_m    = rvld_q ? ram_rdata : 8'h00;

  // Frame parser
  always_comb begin
    mode_d      = mode_q;
    cmd_cnt_d   = cmd_cnt_q;
    data_cnt_d  = data_cnt_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    ram_we      = 1'b0;
    ram_waddr   = data_cnt_q;
    ram_wdata   = code_byte_i;
    start_key   = 1'b0;
    start_frame = 1'b0;
    if (acc && op_i) begin
      if (code_byte_i != 8'h00) begin
        start_key = 1'b1;
        key_d     = code_byte_i;
      end
    end else if (acc) begin
      case (mode_q)
        PM_CMD: begin
          if (cmd_cnt_q < 3'd4) begin
            if (is_printable(code_byte_i)) begin
              cmd_d[cmd_cnt_q[1:0]] = code_byte_i;
              cmd_cnt_d             = cmd_cnt_q + 3'd1;
            end else begin
              mode_d = PM_IDLE;
            end
          end else if (code_byte_i != 8'h00) begin
            mode_d     = PM_DATA;
            ram_we     = 1'b1;
            ram_waddr  = '0;
            data_cnt_d = AW'(1);
          end else begin
            mode_d = PM_IDLE;
          end
        end
        PM_DATA: begin
          if (code_byte_i != 8'h00) begin
            if (data_cnt_q < LAST_IDX) begin
              ram_we     = 1'b1;
              data_cnt_d = data_cnt_q + 1'b1;
            end
          end else begin
            ram_we      = 1'b1;
            ram_wdata   = 8'h00;
            start_frame = 1'b1;
            mode_d      = PM_IDLE;
          end
        end
        default: begin
          if (is_printable(code_byte_i)) begin
            mode_d    = PM_CMD;
            cmd_d[0]  = code_byte_i;
            cmd_cnt_d = 3'd1;
          end
        end
      endcase
    end
  end

  // Reply sequencer
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    idx_d    = idx_q;
    fc_d     = fc_q;
    rc_d     = rc_q;
    a0_d     = a0_q;
    a1_d     = a1_q;
    a2_d     = a2_q;
    ld       = 1'b0;
    nat_last = 1'b0;
    o_kind   = KIND_TX;
    o_val    = 8'h00;
    o_a      = 8'h00;
    o_b      = 8'h00;
    o_c      = 8'h00;
    case (state_q)
      ST_IDLE: begin
        rc_d = '0;
        if (start_key) begin
          state_d = ST_KEY;
          step_d  = '0;
        end else if (start_frame) begin
          state_d = ST_FETCH;
          fc_d    = '0;
        end
      end
      ST_KEY: begin
        if (out_free) begin
          ld = 1'b1;
          if (step_q < 4'd4) begin
            o_val = word_byte(WORD_KEY, step_q[1:0]);
          end else if (step_q == 4'd4) begin
            o_val = key_q;
          end
          nat_last = (step_q == KEY_LAST);
          step_d   = step_q + 4'd1;
        end
      end
      ST_FETCH: begin
        fc_d = fc_q + 2'd1;
        case (fc_q)
          2'd1: a0_d = rdata_m;
          2'd2: a1_d = rdata_m;
          2'd3: begin
            a2_d = rdata_m;
            if (cmd_word == WORD_LCD) begin
              state_d = ST_LCD;
              idx_d   = AW'(1);
            end else if (cmd_word == WORD_LCDC) begin
              state_d = ST_CURSOR;
            end else if (cmd_word == WORD_LED) begin
              if (a1_q >= ASCII_ZERO && a1_q <= ASCII_TWO) begin
                state_d = ST_LED;
              end else begin
                state_d = ST_IDLE;
              end
            end else if (cmd_word == WORD_LOOP) begin
              state_d = ST_LOOP_CMD;
              step_d  = '0;
              idx_d   = '0;
            end else begin
              state_d = ST_IDLE;
            end
          end
          default: ;
        endcase
      end
      ST_LCD: begin
        if (out_free && rdv_q) begin
          ld       = 1'b1;
          o_kind   = KIND_LCD;
          o_val    = rdata_m;
          o_a      = a0_q - ASCII_ZERO;
          nat_last = (rdata_m == 8'h00) || (idx_q == LAST_IDX);
          idx_d    = idx_q + 1'b1;
        end
      end
      ST_CURSOR: begin
        if (out_free) begin
          ld       = 1'b1;
          o_kind   = KIND_CURSOR;
          o_a      = a0_q - ASCII_ZERO;
          o_b      = a1_q - ASCII_ZERO;
          o_c      = a2_q - ASCII_ZERO;
          nat_last = 1'b1;
        end
      end
      ST_LED: begin
        if (out_free) begin
          ld       = 1'b1;
          o_kind   = KIND_LED;
          o_a      = a0_q - ASCII_ZERO;
          o_b      = a1_q - ASCII_ZERO;
          nat_last = 1'b1;
        end
      end
      ST_LOOP_CMD: begin
        if (out_free) begin
          ld     = 1'b1;
          o_val  = cmd_q[step_q[1:0]];
          step_d = step_q + 4'd1;
          if (step_q == 4'd3) begin
            state_d = ST_LOOP_DATA;
          end
        end
      end
      ST_LOOP_DATA: begin
        if (out_free && rdv_q) begin
          ld    = 1'b1;
          o_val = rdata_m;
          idx_d = idx_q + 1'b1;
          if (rdata_m == 8'h00 || idx_q == LOOP_END) begin
            state_d = ST_LOOP_PAD;
            step_d  = '0;
          end
        end
      end
      ST_LOOP_PAD: begin
        if (out_free) begin
          ld       = 1'b1;
          nat_last = (step_q == 4'd3);
          step_d   = step_q + 4'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (ld) begin
      rc_d = rc_q + 1'b1;
    end
    if (ld && res_last) begin
      state_d = ST_IDLE;
    end
  end

  assign res_last = nat_last || (rc_q == RC_LAST);
  assign mem_adv  = ld && (state_q == ST_LCD || state_q == ST_LOOP_DATA)
                    && (idx_q != LAST_IDX);
  assign ram_raddr = (state_q == ST_FETCH) ? AW'(fc_q)
                   : (mem_adv ? idx_q + 1'b1 : idx_q);

  scfp_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= PM_IDLE;
      cmd_cnt_q  <= '0;
      data_cnt_q <= '0;
      cmd_q      <= '{default: 8'h00};
      state_q    <= ST_IDLE;
      step_q     <= '0;
      idx_q      <= '0;
      fc_q       <= '0;
      rc_q       <= '0;
      rdv_q      <= 1'b0;
      vld_q      <= '0;
      rvld_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      cmd_cnt_q  <= cmd_cnt_d;
      data_cnt_q <= data_cnt_d;
      cmd_q      <= cmd_d;
      state_q    <= state_d;
      step_q     <= step_d;
      idx_q      <= idx_d;
      fc_q       <= fc_d;
      rc_q       <= rc_d;
      rdv_q      <= (state_d == state_q);
      rvld_q     <= vld_q[ram_raddr];
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (ld) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    a0_q  <= a0_d;
    a1_q  <= a1_d;
    a2_q  <= a2_d;
    if (ld) begin
      out_kind_q <= o_kind;
      out_val_q  <= o_val;
      out_a_q    <= o_a;
      out_b_q    <= o_b;
      out_c_q    <= o_c;
      out_last_q <= res_last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign kind_o       = out_kind_q;
  assign value_byte_o = out_val_q;
  assign arg_a_o      = out_a_q;
  assign arg_b_o      = out_b_q;
  assign arg_c_o      = out_c_q;
  assign last_o       = out_last_q;

  a_no_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !ram_we)
    else $error("buffer written during a reply run");

  a_data_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_cnt_q <= LAST_IDX)
    else $error("data count beyond buffer");

  a_cmd_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == PM_CMD) |-> (cmd_cnt_q >= 3'd1 && cmd_cnt_q <= 3'd4))
    else $error("command count out of range in command mode");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld && out_vld_q) |-> out_ready_i)
    else $error("output register overwritten before transaction");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for serial_command_frame_parser_core: drives serial bytes and key events,
// predicts every reply in a behavioral parser and checks each output transaction.
// Depends on scfp_pkg and the core RTL.
module testbench;
  import scfp_pkg::*;

  localparam int unsigned DEPTH       = DEF_DATA_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN       = 40;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] arg_a;
    logic [7:0] arg_b;
    logic [7:0] arg_c;
    logic       last;
  } reply_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       op         = 1'b0;
  logic [7:0] code_byte  = 8'h00;
  logic       out_ready  = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] kind;
  logic [7:0] value_byte;
  logic [7:0] arg_a;
  logic [7:0] arg_b;
  logic [7:0] arg_c;
  logic       last;

  // parser mirror
  pmode_e      pmode;
  int unsigned cmd_cnt;
  int unsigned data_cnt;
  logic [7:0]  cmd_chars [4];
  logic [7:0]  data_buf [DEPTH+1];

  reply_t pending_replies[$];
  reply_t reply_run[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int key_events     = 0;
  int frames_closed  = 0;
  int replies_seen   = 0;
  int error_count    = 0;
  int unsigned cycle_count = 0;

  serial_command_frame_parser_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op),
    .code_byte_i  (code_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .kind_o       (kind),
    .value_byte_o (value_byte),
    .arg_a_o      (arg_a),
    .arg_b_o      (arg_b),
    .arg_c_o      (arg_c),
    .last_o       (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               pending_replies.size());
      $display("testbench failed");
      $finish;
    end
  end

  function automatic void add_reply(input logic [1:0] k, input logic [7:0] v,
                                    input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c);
    reply_t r;
    if (reply_run.size() < MAX_RESULTS) begin
      r.kind  = k;
      r.value = v;
      r.arg_a = a;
      r.arg_b = b;
      r.arg_c = c;
      r.last  = 1'b0;
      reply_run.push_back(r);
    end
  endfunction

  function automatic void add_tx_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_reply(KIND_TX, w[31-8*i -: 8], 8'h00, 8'h00, 8'h00);
  endfunction

  function automatic void add_tx_pad();
    for (int i = 0; i < 4; i++) add_reply(KIND_TX, 8'h00, 8'h00, 8'h00, 8'h00);
  endfunction

  function automatic void decode_frame_replies();
    logic [31:0] cmd;
    logic [7:0]  line;
    cmd  = {cmd_chars[0], cmd_chars[1], cmd_chars[2], cmd_chars[3]};
    line = data_buf[0] - ASCII_ZERO;
    if (cmd == WORD_LCD) begin
      for (int i = 1; i <= DEPTH; i++) begin
        add_reply(KIND_LCD, data_buf[i], line, 8'h00, 8'h00);
        if (data_buf[i] == 8'h00) break;
      end
    end else if (cmd == WORD_LCDC) begin
      add_reply(KIND_CURSOR, 8'h00, line, data_buf[1] - ASCII_ZERO, data_buf[2] - ASCII_ZERO);
    end else if (cmd == WORD_LED) begin
      if (data_buf[1] >= ASCII_ZERO && data_buf[1] <= ASCII_TWO)
        add_reply(KIND_LED, 8'h00, line, data_buf[1] - ASCII_ZERO, 8'h00);
    end else if (cmd == WORD_LOOP) begin
      add_tx_word(WORD_LOOP);
      for (int i = 0; i < DEPTH; i++) begin
        add_reply(KIND_TX, data_buf[i], 8'h00, 8'h00, 8'h00);
        if (data_buf[i] == 8'h00) break;
      end
      add_tx_pad();
    end
  endfunction

  function automatic void parse_rx_item(input logic is_key, input logic [7:0] b);
    logic printable;
    printable = (b >= PRINT_LO) && (b < PRINT_HI);
    reply_run = {};
    if (is_key) begin
      key_events++;
      if (b != 8'h00) begin
        add_tx_word(WORD_KEY);
        add_reply(KIND_TX, b, 8'h00, 8'h00, 8'h00);
        add_reply(KIND_TX, 8'h00, 8'h00, 8'h00, 8'h00);
        add_tx_pad();
      end
    end else begin
      case (pmode)
        PM_CMD: begin
          if (cmd_cnt < 4) begin
            if (printable) begin
              cmd_chars[cmd_cnt] = b;
              cmd_cnt++;
            end else begin
              pmode = PM_IDLE;
            end
          end else if (b != 8'h00) begin
            pmode       = PM_DATA;
            data_buf[0] = b;
            data_cnt    = 1;
          end else begin
            pmode = PM_IDLE;
          end
        end
        PM_DATA: begin
          if (b != 8'h00) begin
            if (data_cnt < DEPTH) begin
              data_buf[data_cnt] = b;
              data_cnt++;
            end
          end else begin
            data_buf[data_cnt] = 8'h00;
            frames_closed++;
            decode_frame_replies();
            pmode = PM_IDLE;
          end
        end
        default: begin
          if (printable) begin
            pmode        = PM_CMD;
            cmd_chars[0] = b;
            cmd_cnt      = 1;
          end
        end
      endcase
    end
    if (reply_run.size() > 0) reply_run[reply_run.size()-1].last = 1'b1;
    foreach (reply_run[i]) pending_replies.push_back(reply_run[i]);
  endfunction

  task automatic send_item(input logic is_key, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= is_key;
    code_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    parse_rx_item(is_key, b);
  endtask

  task automatic send_word_chars(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_item(1'b0, w[31-8*i -: 8]);
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    got = '{kind, value_byte, arg_a, arg_b, arg_c, last};
    if (out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        if (error_count < 10)
          $display("unexpected reply kind=%0d value=%02h a=%02h b=%02h c=%02h last=%0d",
                   got.kind, got.value, got.arg_a, got.arg_b, got.arg_c, got.last);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        replies_seen++;
        if (got !== want) begin
          if (error_count < 10) begin
            $display("reply %0d mismatch", replies_seen);
            $display("  exp kind=%0d value=%02h a=%02h b=%02h c=%02h last=%0d",
                     want.kind, want.value, want.arg_a, want.arg_b, want.arg_c, want.last);
            $display("  got kind=%0d value=%02h a=%02h b=%02h c=%02h last=%0d",
                     got.kind, got.value, got.arg_a, got.arg_b, got.arg_c, got.last);
          end
          error_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic test_key_events();
    send_item(1'b1, 8'hff);
    send_item(1'b1, 8'h00);
  endtask

  task automatic test_idle_noise();
    send_item(1'b0, 8'h00);
    send_item(1'b0, PRINT_HI);
  endtask

  task automatic test_command_abort();
    send_item(1'b0, "L");
    send_item(1'b0, "C");
    send_item(1'b0, PRINT_LO - 8'd1);
  endtask

  // data byte 0x01 is the smallest accepted, one byte of data only
  task automatic test_loop_min_data();
    send_word_chars(WORD_LOOP);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'h00);
  endtask

  // row and visible flag come from whatever the buffer holds
  task automatic test_cursor_short_data();
    send_word_chars(WORD_LCDC);
    send_item(1'b0, "5");
    send_item(1'b0, 8'h00);
  endtask

  task automatic test_led_bad_action();
    send_word_chars(WORD_LED);
    send_item(1'b0, "1");
    send_item(1'b0, "x");
    send_item(1'b0, 8'h00);
  endtask

  task automatic send_random_frame();
    logic [31:0] w;
    logic [7:0]  b;
    int          len;
    int          pos;
    case ($urandom_range(5))
      0:       w = WORD_LCD;
      1:       w = WORD_LCDC;
      2:       w = WORD_LED;
      3:       w = WORD_LOOP;
      4: begin
        w   = ($urandom_range(1)) ? WORD_LCD : WORD_LOOP;
        pos = $urandom_range(3);
        w[8*pos +: 8] = 8'($urandom_range(8'h20, 8'h7e));
      end
      default: w = {8'($urandom_range(8'h20, 8'h7e)), 8'($urandom_range(8'h20, 8'h7e)),
                    8'($urandom_range(8'h20, 8'h7e)), 8'($urandom_range(8'h20, 8'h7e))};
    endcase
    len = ($urandom_range(9) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 6) : $urandom_range(1, 6);
    send_word_chars(w);
    for (int i = 0; i < len; i++) begin
      if (i < 3 && $urandom_range(1)) b = ASCII_ZERO + 8'($urandom_range(3));
      else b = 8'($urandom_range(1, 255));
      if ($urandom_range(29) == 0) send_item(1'b1, 8'($urandom_range(255)));
      send_item(1'b0, b);
    end
    send_item(1'b0, 8'h00);
  endtask

  task automatic send_broken_frame();
    int n;
    if ($urandom_range(1)) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) send_item(1'b0, 8'($urandom_range(8'h20, 8'h7e)));
      if ($urandom_range(1)) send_item(1'b0, 8'($urandom_range(8'h00, 8'h1f)));
      else send_item(1'b0, 8'($urandom_range(8'h7f, 8'hff)));
    end else begin
      send_word_chars(($urandom_range(1)) ? WORD_LED : WORD_LCDC);
      send_item(1'b0, 8'h00);
    end
  endtask

  task automatic test_random_frames(input int n_items, input int idle_pct, input int stall_pct);
    int target;
    int pick;
    target         = items_sent + n_items;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) send_random_frame();
      else if (pick < 80)
        send_item(1'b1, ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255)));
      else if (pick < 90) send_item(1'b0, 8'($urandom_range(255)));
      else send_broken_frame();
    end
  endtask

  initial begin
    pmode    = PM_IDLE;
    cmd_cnt  = 0;
    data_cnt = 0;
    foreach (cmd_chars[i]) cmd_chars[i] = 8'h00;
    foreach (data_buf[i]) data_buf[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_key_events();
    test_idle_noise();
    test_command_abort();
    test_loop_min_data();
    test_cursor_short_data();
    test_led_bad_action();
    test_random_frames(75, 0, 0);
    test_random_frames(75, 48, 0);
    test_random_frames(75, 0, 48);
    test_random_frames(75, 22, 22);
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("%0d input transactions (%0d key events, %0d frames closed), %0d replies checked",
             items_sent, key_events, frames_closed, replies_seen);
    $display("pacing phases: free running, sender gaps, receiver stalls, both; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
